@@ hw/rtl/cpio_pkg.sv @@
// Shared types and constants for the cpio newc stream parser.
// No dependencies.
package cpio_pkg;

    localparam logic [3:0] PH_HDR  = 4'd0;
    localparam logic [3:0] PH_SKIP = 4'd1;
    localparam logic [3:0] PH_NAME = 4'd2;
    localparam logic [3:0] PH_NPAD = 4'd3;
    localparam logic [3:0] PH_DATA = 4'd4;
    localparam logic [3:0] PH_DPAD = 4'd5;
    localparam logic [3:0] PH_DONE = 4'd6;
    localparam logic [3:0] PH_ERR1 = 4'd7;
    localparam logic [3:0] PH_ERR2 = 4'd8;
    localparam logic [3:0] PH_ERR3 = 4'd9;
    localparam logic [3:0] PH_ERR4 = 4'd10;

    localparam logic [3:0] K_HDR   = 4'd0;
    localparam logic [3:0] K_HDRE  = 4'd1;
    localparam logic [3:0] K_NAME  = 4'd2;
    localparam logic [3:0] K_NAMEE = 4'd3;
    localparam logic [3:0] K_PAD   = 4'd4;
    localparam logic [3:0] K_DATA  = 4'd5;
    localparam logic [3:0] K_DONE  = 4'd6;
    localparam logic [3:0] K_ERR   = 4'd7;
    localparam logic [3:0] K_IGN   = 4'd8;

    localparam int HDR_LEN = 110;

    // Classified beat handed from front to back.
    typedef struct packed {
        logic [7:0] byte_val;
        logic [3:0] nib;
    } t_beat;

    // Result beat.
    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  payload_byte;
        logic [2:0]  entry_type;
        logic [11:0] perm_bits;
        logic [31:0] file_size;
        logic [31:0] dev_major;
        logic [31:0] dev_minor;
        logic [31:0] name_length;
        logic        is_trailer;
        logic        is_dot;
        logic [2:0]  error_code;
        logic [15:0] entry_count;
    } t_res;

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            v = c[3:0] + 4'd9;
        return v;
    endfunction

    function automatic logic [7:0] magic_chr(input logic [2:0] i);
        logic [7:0] v;
        unique case (i)
            3'd1, 3'd3: v = 8'h37;
            3'd5:       v = 8'h31;
            default:    v = 8'h30;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] trailer_chr(input logic [3:0] i);
        logic [7:0] v;
        unique case (i)
            4'd0: v = 8'h54;
            4'd1: v = 8'h52;
            4'd2: v = 8'h41;
            4'd3: v = 8'h49;
            4'd4: v = 8'h4C;
            4'd5: v = 8'h45;
            4'd6: v = 8'h52;
            default: v = 8'h21;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/cpio_front.sv @@
// Front end: accepts archive bytes, predecodes the hex digit, feeds a
// two-entry queue. Depends on cpio_pkg.
module cpio_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_in_byte,
    output logic            o_q_valid,
    input  logic            i_q_pop,
    output cpio_pkg::t_beat o_q_beat
);
    cpio_pkg::t_beat r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            push;
    cpio_pkg::t_beat n_beat;

    assign o_stall   = r_cnt[1];
    assign push      = i_valid && !o_stall;
    assign o_q_valid = r_cnt != 2'd0;
    assign o_q_beat  = r_mem[r_rp];

    always_comb begin
        n_beat.byte_val  = i_in_byte;
        n_beat.nib       = cpio_pkg::hex_val(i_in_byte);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count out of range");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop from empty queue");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> o_stall) else $error("full queue not stalled");
endmodule

@@ hw/rtl/cpio_back.sv @@
// Back end: phase machine, hex field decode, alignment, output register.
// Depends on cpio_pkg.
module cpio_back #(
    parameter int COUNT_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [31:0]     i_size,
    input  logic            i_q_valid,
    output logic            o_q_pop,
    input  cpio_pkg::t_beat i_q_beat,
    output logic            o_valid,
    input  logic            i_stall,
    output cpio_pkg::t_res  o_res
);
    logic [3:0]  r_phase, n_phase;
    logic [31:0] r_off, r_cnt, n_cnt;
    logic [31:0] r_mode, r_fsz, r_maj, r_min, r_nlen;
    logic [31:0] n_mode, n_fsz, n_maj, n_min, n_nlen;
    logic [1:0]  r_flags, n_flags;
    logic [COUNT_BITS-1:0] r_ents, n_ents;
    logic        r_valid;
    cpio_pkg::t_res r_res, n_res;

    logic        go;
    logic [7:0]  c;
    logic [32:0] off1, nend, doff, sz33;
    logic [33:0] sum_data;
    logic        last, trl, dot, pay;
    logic [3:0]  kind;
    logic [31:0] idx;
    logic [2:0]  etype;
    logic [3:0]  fmt;
    logic [1:0]  pad;

    assign go      = i_q_valid && (!r_valid || !i_stall);
    assign o_q_pop = go;
    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign c       = i_q_beat.byte_val;
    assign sz33    = {1'b0, i_size};
    assign off1    = {1'b0, r_off} + 33'd1;
    assign last    = off1 >= sz33;
    assign nend    = off1;
    assign doff    = (nend + 33'd3) & ~33'd3;
    assign sum_data = {1'b0, doff} + {2'b0, n_fsz};
    assign pad     = 2'd0 - off1[1:0];

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_mode  = r_mode;
        n_fsz   = r_fsz;
        n_maj   = r_maj;
        n_min   = r_min;
        n_nlen  = r_nlen;
        n_flags = r_flags;
        n_ents  = r_ents;
        kind    = cpio_pkg::K_IGN;
        pay     = 1'b0;
        trl     = 1'b0;
        dot     = 1'b0;
        idx     = r_cnt;
        unique case (r_phase)
            cpio_pkg::PH_HDR: begin
                priority if (r_cnt == 32'd0 && ({1'b0, r_off} + 33'd110) > sz33) begin
                    n_phase = cpio_pkg::PH_ERR1;
                    kind    = cpio_pkg::K_ERR;
                end else if (r_cnt == 32'd0 && c == 8'd0) begin
                    n_phase = cpio_pkg::PH_SKIP;
                    n_cnt   = 32'd3;
                end else if (r_cnt < 32'd6 && c != cpio_pkg::magic_chr(r_cnt[2:0])) begin
                    n_phase = cpio_pkg::PH_ERR2;
                    kind    = cpio_pkg::K_ERR;
                    if (r_cnt == 32'd0) begin
                        n_mode = '0; n_fsz = '0; n_maj = '0; n_min = '0; n_nlen = '0;
                        n_flags = 2'b11;
                    end
                end else begin
                    if (r_cnt == 32'd0) begin
                        n_mode = '0; n_fsz = '0; n_maj = '0; n_min = '0; n_nlen = '0;
                        n_flags = 2'b11;
                    end
                    if (r_cnt >= 32'd14 && r_cnt < 32'd22)
                        n_mode = {r_mode[27:0], i_q_beat.nib};
                    else if (r_cnt >= 32'd54 && r_cnt < 32'd62)
                        n_fsz = {r_fsz[27:0], i_q_beat.nib};
                    else if (r_cnt >= 32'd78 && r_cnt < 32'd86)
                        n_maj = {r_maj[27:0], i_q_beat.nib};
                    else if (r_cnt >= 32'd86 && r_cnt < 32'd94)
                        n_min = {r_min[27:0], i_q_beat.nib};
                    else if (r_cnt >= 32'd94 && r_cnt < 32'd102)
                        n_nlen = {r_nlen[27:0], i_q_beat.nib};
                    if (r_cnt < 32'd109) begin
                        n_cnt = r_cnt + 32'd1;
                        kind  = cpio_pkg::K_HDR;
                    end else begin
                        n_cnt = 32'd0;
                        if (off1 + {1'b0, n_nlen} > sz33) begin
                            n_phase = cpio_pkg::PH_ERR3;
                            kind    = cpio_pkg::K_ERR;
                        end else if (n_nlen == 32'd0) begin
                            kind = cpio_pkg::K_HDRE;
                        end else begin
                            n_phase = cpio_pkg::PH_NAME;
                            n_cnt   = n_nlen;
                            kind    = cpio_pkg::K_HDRE;
                        end
                    end
                end
            end
            cpio_pkg::PH_SKIP: begin
                if (r_cnt <= 32'd1) begin
                    n_cnt = 32'd0;
                    if (last) begin
                        n_phase = cpio_pkg::PH_DONE;
                        kind    = cpio_pkg::K_DONE;
                    end else begin
                        n_phase = cpio_pkg::PH_HDR;
                    end
                end else begin
                    n_cnt = r_cnt - 32'd1;
                end
            end
            cpio_pkg::PH_NAME: begin
                pay = 1'b1;
                idx = r_nlen - r_cnt;
                if (r_nlen != 32'd11 || (idx < 32'd10 && c != cpio_pkg::trailer_chr(idx[3:0])))
                    n_flags[0] = 1'b0;
                if ((idx == 32'd0 && c != 8'h2E) || (idx == 32'd1 && c != 8'd0))
                    n_flags[1] = 1'b0;
                if (r_cnt <= 32'd1) begin
                    n_cnt = 32'd0;
                    kind  = cpio_pkg::K_NAMEE;
                end else begin
                    n_cnt = r_cnt - 32'd1;
                    kind  = cpio_pkg::K_NAME;
                end
            end
            cpio_pkg::PH_NPAD, cpio_pkg::PH_DATA, cpio_pkg::PH_DPAD: begin
                pay  = r_phase == cpio_pkg::PH_DATA;
                kind = pay ? cpio_pkg::K_DATA : cpio_pkg::K_PAD;
                priority if (last) begin
                    n_phase = cpio_pkg::PH_DONE;
                    kind    = cpio_pkg::K_DONE;
                end else if (r_cnt > 32'd1) begin
                    n_cnt = r_cnt - 32'd1;
                end else begin
                    n_cnt = 32'd0;
                    if (r_phase == cpio_pkg::PH_NPAD && r_fsz != 32'd0) begin
                        n_phase = cpio_pkg::PH_DATA;
                        n_cnt   = r_fsz;
                    end else if (r_phase == cpio_pkg::PH_DATA && off1[1:0] != 2'd0) begin
                        n_phase = cpio_pkg::PH_DPAD;
                        n_cnt   = {30'd0, pad};
                    end else begin
                        n_phase = cpio_pkg::PH_HDR;
                    end
                end
            end
            default: kind = cpio_pkg::K_IGN;
        endcase

        // End of name: header with zero namesize or last name byte.
        if (kind == cpio_pkg::K_NAMEE || (kind == cpio_pkg::K_HDRE && n_nlen == 32'd0)) begin
            trl = n_nlen == 32'd11 && n_flags[0];
            dot = n_nlen >= 32'd2 && n_flags[1];
            priority if (trl) begin
                n_phase = cpio_pkg::PH_DONE;
                kind    = cpio_pkg::K_DONE;
            end else if (sum_data > {1'b0, sz33}) begin
                n_phase = cpio_pkg::PH_ERR4;
                kind    = cpio_pkg::K_ERR;
            end else begin
                if (!dot && r_ents != {COUNT_BITS{1'b1}}) n_ents = r_ents + 1'b1;
                priority if (nend >= sz33) begin
                    n_phase = cpio_pkg::PH_DONE;
                    kind    = cpio_pkg::K_DONE;
                end else if (doff > nend) begin
                    n_phase = cpio_pkg::PH_NPAD;
                    n_cnt   = {30'd0, doff[1:0] - nend[1:0]};
                end else if (n_fsz != 32'd0) begin
                    n_phase = cpio_pkg::PH_DATA;
                    n_cnt   = n_fsz;
                end else begin
                    n_phase = cpio_pkg::PH_HDR;
                    n_cnt   = 32'd0;
                end
            end
        end

        fmt = n_mode[15:12];
        unique case (fmt)
            4'o04:   etype = 3'd0;
            4'o12:   etype = 3'd1;
            4'o02:   etype = 3'd2;
            4'o10:   etype = 3'd3;
            default: etype = 3'd4;
        endcase

        n_res.kind         = kind;
        n_res.payload_byte = pay ? c : 8'd0;
        n_res.entry_type   = etype;
        n_res.perm_bits    = n_mode[11:0];
        n_res.file_size    = n_fsz;
        n_res.dev_major    = n_maj;
        n_res.dev_minor    = n_min;
        n_res.name_length  = n_nlen;
        n_res.is_trailer   = trl;
        n_res.is_dot       = dot;
        n_res.error_code   = (n_phase >= cpio_pkg::PH_ERR1 && n_phase <= cpio_pkg::PH_ERR4)
                             ? 3'(n_phase - cpio_pkg::PH_ERR1 + 4'd1) : 3'd0;
        n_res.entry_count  = 16'(n_ents);
    end

    always_ff @(posedge i_clk) begin
        if (go) r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cpio_pkg::PH_HDR;
            r_off   <= '0;
            r_cnt   <= '0;
            r_mode  <= '0;
            r_fsz   <= '0;
            r_maj   <= '0;
            r_min   <= '0;
            r_nlen  <= '0;
            r_flags <= 2'b11;
            r_ents  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (go) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_mode  <= n_mode;
                r_fsz   <= n_fsz;
                r_maj   <= n_maj;
                r_min   <= n_min;
                r_nlen  <= n_nlen;
                r_flags <= n_flags;
                r_ents  <= n_ents;
                if (r_phase < cpio_pkg::PH_DONE) r_off <= r_off + 32'd1;
            end
            if (go) r_valid <= 1'b1;
            else if (!i_stall) r_valid <= 1'b0;
        end
    end

    a_end_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase >= cpio_pkg::PH_DONE |=> r_phase == $past(r_phase))
        else $error("end phase left");
    a_off_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase >= cpio_pkg::PH_DONE |=> $stable(r_off)) else $error("offset moved after end");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid && $stable(r_res)) else $error("result lost");
endmodule

@@ hw/rtl/cpio_newc_stream_parser.sv @@
// Top level of the cpio newc stream parser: config register, front queue,
// back phase machine. Depends on cpio_pkg, cpio_front, cpio_back.
//
//  channel  | handshake                     | beat
//  in       | i_valid / o_stall             | i_in_byte
//  out      | o_valid / i_stall             | o_kind .. o_entry_count
//  cfg      | i_cfg_we                      | i_cfg_wdata (archive_size)
//
// One byte per cycle sustained while i_stall is low; each byte passes through the queue, then the result register.
// The back phase machine retires one queued beat per cycle while the output is not stalled.
// Synchronous active-low reset; no clearing pass.
// Output stall backs up the two-entry queue, then raises o_stall.
module cpio_newc_stream_parser #(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [2:0]  o_entry_type,
    output logic [11:0] o_perm_bits,
    output logic [31:0] o_file_size,
    output logic [31:0] o_dev_major,
    output logic [31:0] o_dev_minor,
    output logic [31:0] o_name_length,
    output logic        o_is_trailer,
    output logic        o_is_dot,
    output logic [2:0]  o_error_code,
    output logic [15:0] o_entry_count
);
    logic [31:0]     r_size;
    logic            q_valid, q_pop;
    cpio_pkg::t_beat q_beat;
    cpio_pkg::t_res  res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_size <= '0;
        else if (i_cfg_we) r_size <= i_cfg_wdata;
    end

    cpio_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_in_byte,
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_beat(q_beat)
    );

    cpio_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk, .i_rst_n, .i_size(r_size),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_beat(q_beat),
        .o_valid, .i_stall, .o_res(res)
    );

    assign o_kind         = res.kind;
    assign o_payload_byte = res.payload_byte;
    assign o_entry_type   = res.entry_type;
    assign o_perm_bits    = res.perm_bits;
    assign o_file_size    = res.file_size;
    assign o_dev_major    = res.dev_major;
    assign o_dev_minor    = res.dev_minor;
    assign o_name_length  = res.name_length;
    assign o_is_trailer   = res.is_trailer;
    assign o_is_dot       = res.is_dot;
    assign o_error_code   = res.error_code;
    assign o_entry_count  = res.entry_count;
endmodule
